// ===== rtl/upd_pkg.sv =====
// Shared types, constants and hex helpers for the URL percent decoder.
package upd_pkg;

    // Escape phases of the front end
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // Characters
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] UA_BIAS  = CH_UA - 8'd10;
    localparam logic [7:0] LA_BIAS  = CH_LA - 8'd10;

    // Command queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One classified input: up to three bytes to emit, in order
    typedef struct packed {
        logic [1:0]      cnt;    // 1..3 bytes
        logic            fin;    // last input of the text
        logic [2:0][7:0] bytes;  // bytes[0] goes out first
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= CH_0) && (c <= CH_9)) ||
                 ((c >= CH_UA) && (c <= CH_UF)) ||
                 ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c - CH_0;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = c - UA_BIAS;
        end else begin
            v = c - LA_BIAS;
        end
        hex_val = v[3:0];
    endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: tracks the escape phase and turns each input byte into a command.
module upd_front import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    output logic [1:0] o_phase
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first, n_first;
    t_cmd       w_cmd;
    logic       w_hex;

    assign w_hex = is_hex(i_in_byte);

    // Classify the byte against the current phase
    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        w_cmd     = '0;
        w_cmd.fin = i_is_final;
        case (r_phase)
            PH_PCT: begin
                if (w_hex) begin
                    if (i_is_final) begin
                        w_cmd.bytes[0] = CH_PCT;
                        w_cmd.bytes[1] = i_in_byte;
                        w_cmd.cnt      = 2'd2;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_first = i_in_byte;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    // bad first digit: emit '%' and rescan
                    w_cmd.bytes[0] = CH_PCT;
                    if (i_in_byte == CH_PCT && !i_is_final) begin
                        w_cmd.cnt = 2'd1;
                        n_phase   = PH_PCT;
                    end else begin
                        w_cmd.bytes[1] = i_in_byte;
                        w_cmd.cnt      = 2'd2;
                        n_phase        = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    w_cmd.bytes[0] = {hex_val(r_first), hex_val(i_in_byte)};
                    w_cmd.cnt      = 2'd1;
                    n_phase        = PH_IDLE;
                end else begin
                    // bad second digit: emit '%' and first digit, then rescan
                    w_cmd.bytes[0] = CH_PCT;
                    w_cmd.bytes[1] = r_first;
                    if (i_in_byte == CH_PCT && !i_is_final) begin
                        w_cmd.cnt = 2'd2;
                        n_phase   = PH_PCT;
                    end else begin
                        w_cmd.bytes[2] = i_in_byte;
                        w_cmd.cnt      = 2'd3;
                        n_phase        = PH_IDLE;
                    end
                end
            end
            default: begin
                if (i_in_byte == CH_PCT && !i_is_final) begin
                    n_phase = PH_PCT;
                end else begin
                    w_cmd.bytes[0] = i_in_byte;
                    w_cmd.cnt      = 2'd1;
                    n_phase        = PH_IDLE;
                end
            end
        endcase
        if (i_is_final) begin
            n_phase = PH_IDLE;
        end
    end

    // Phase and first digit advance on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    assign o_cmd_valid = i_accept && (w_cmd.cnt != 2'd0);
    assign o_cmd       = w_cmd;
    assign o_phase     = r_phase;

endmodule

// ===== rtl/upd_cmdq.sv =====
// Small command queue between the front end and the output sequencer.
module upd_cmdq import upd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  t_cmd            i_wdata,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_empty,
    output t_cmd            o_rdata,
    output logic [Q_CW-1:0] o_count
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            w_wr, w_rd;

    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + Q_CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/upd_back.sv =====
// Back end: walks the bytes of the head command out one per transfer.
module upd_back import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_done,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    logic [1:0] r_idx;
    logic       w_last, w_xfer;

    assign w_last = (r_idx == (i_cmd.cnt - 2'd1));
    assign w_xfer = i_pop && !i_cmd_empty;

    // Byte index within the head command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_xfer) begin
            r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Result fields
    always_comb begin
        case (r_idx)
            2'd0:    o_out_byte = i_cmd.bytes[0];
            2'd1:    o_out_byte = i_cmd.bytes[1];
            default: o_out_byte = i_cmd.bytes[2];
        endcase
    end

    assign o_empty    = i_cmd_empty;
    assign o_run_last = w_last;
    assign o_text_end = w_last && i_cmd.fin;
    assign o_cmd_done = w_xfer && w_last;

endmodule

// ===== rtl/url_percent_decoder_core.sv =====
// Top level of the streaming URL percent decoder.
//
// Input channel: i_in_byte / i_is_final, transferred when i_push is high and
// o_full is low. Set i_is_final on the last byte of a text; any pending
// escape that the final byte does not complete is then flushed literally.
// Result channel: o_out_byte / o_run_last / o_text_end, valid while o_empty
// is low, transferred when i_pop is high. o_run_last marks the last result of
// one input byte, o_text_end the last result of a text.
// Each input byte is classified in the cycle it is transferred and its 0 to 3
// result bytes are queued as one command in a 4-entry command queue.
// The results of a byte appear once its command is written to the queue and reaches its head.
// Throughput: one input byte per cycle while results are popped every cycle;
// the output side moves one result byte per cycle, so a byte that expands to
// two or three results holds the output until each result is popped, and the input
// side stalls (o_full) only once the command queue has filled.
// A byte that yields no result (an escape in progress) uses no queue entry.
// Reset (synchronous, active low) clears the escape phase and empties the
// queue. A stalled receiver leaves the head result unchanged on the ports.
module url_percent_decoder_core import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    logic            w_accept;
    logic            w_cmd_valid;
    t_cmd            w_cmd;
    logic [1:0]      w_phase;
    logic            w_q_empty;
    t_cmd            w_head;
    logic            w_cmd_done;
    logic [Q_CW-1:0] w_q_count;

    assign w_accept = i_push && !o_full;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in_byte   (i_in_byte),
        .i_is_final  (i_is_final),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .o_phase     (w_phase)
    );

    upd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_valid),
        .i_wdata (w_cmd),
        .i_rd    (w_cmd_done),
        .o_full  (o_full),
        .o_empty (w_q_empty),
        .o_rdata (w_head),
        .o_count (w_q_count)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_q_empty),
        .i_cmd       (w_head),
        .o_cmd_done  (w_cmd_done),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_end  (o_text_end)
    );

`ifndef SYNTHESIS
    // Queue never overfills
    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= Q_CW'(Q_DEPTH))
        else $error("command queue count out of range");

    // No empty command ever reaches the head
    a_head_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_empty |-> (w_head.cnt != 2'd0))
        else $error("empty command at queue head");

    // A final byte always leaves the front end idle
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_is_final) |=> (w_phase == PH_IDLE))
        else $error("escape phase pending after final byte");

    // Results of one input byte come out without a gap in validity
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_run_last) |=> !o_empty)
        else $error("result run broken off");
`endif

endmodule
